// ----- rtl/cdq_pkg.sv -----
// Package for the circular deque with cursor.
// Holds request and status codes and parameter defaults; no dependencies.
`default_nettype none

package cdq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 64;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5,
    REQ_CURSOR_RD  = 3'd6
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Ring access requested by the pointer logic for one word.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/cdq_ring.sv -----
// Ring store of the deque: one write or one registered read per cycle.
// Depends on cdq_pkg for the access command struct.
`default_nettype none

module cdq_ring #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 64,
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire cdq_pkg::mem_cmd_t      cmd,
  input  wire logic [IDX_W-1:0]       addr,
  input  wire logic [DATA_WIDTH-1:0]  wdata,
  output logic      [DATA_WIDTH-1:0]  rdata_r
);
  import cdq_pkg::*;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cdq_ctrl.sv -----
// Pointer and cursor control of the deque: decodes one request per cycle,
// picks the ring slot, updates front, count and cursor, registers status.
// Depends on cdq_pkg.
`default_nettype none

module cdq_ctrl #(
  parameter int DEPTH  = 16,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic [2:0]         req_type,
  output cdq_pkg::mem_cmd_t       mem_cmd,
  output logic      [IDX_W-1:0]   mem_addr,
  output logic                    res_valid_r,
  output cdq_pkg::status_t        res_status_r,
  output logic                    res_rd_sel_r,
  output logic      [CNT_W-1:0]   count_r
);
  import cdq_pkg::*;

  localparam int SUM_W = IDX_W + 1;

  logic [IDX_W-1:0] front_r,  front_nxt;
  logic [CNT_W-1:0] count_nxt;
  logic [IDX_W-1:0] cursor_r, cursor_nxt;
  status_t          status_nxt;
  logic             rd_sel_nxt;

  logic             is_full, is_empty;
  logic [IDX_W-1:0] slot_back_push, slot_back_peek, slot_cursor, front_dec;
  logic [CNT_W-1:0] cur_pos, cur_inc;

  // Fold a sum below twice the depth back into the ring.
  function automatic logic [IDX_W-1:0] wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] t;
    t = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
    return t[IDX_W-1:0];
  endfunction

  always_comb begin
    is_full  = (count_r == CNT_W'(DEPTH));
    is_empty = (count_r == '0);

    slot_back_push = wrap(SUM_W'(front_r) + SUM_W'(count_r));
    slot_back_peek = wrap(SUM_W'(front_r) + SUM_W'(count_r - CNT_W'(1)));
    front_dec      = (front_r == '0) ? IDX_W'(DEPTH - 1) : (front_r - IDX_W'(1));

    cur_pos     = (CNT_W'(cursor_r) < count_r) ? CNT_W'(cursor_r) : '0;
    cur_inc     = cur_pos + CNT_W'(1);
    slot_cursor = wrap(SUM_W'(front_r) + SUM_W'(cur_pos));
  end

  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    status_nxt = ST_OK;
    rd_sel_nxt = 1'b0;
    mem_cmd    = '0;
    mem_addr   = front_r;
    case (req_t'(req_type))
      REQ_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          front_nxt     = front_dec;
          count_nxt     = count_r + CNT_W'(1);
          cursor_nxt    = '0;
          mem_cmd.wr_en = 1'b1;
          mem_addr      = front_dec;
        end
      end
      REQ_PUSH_BACK: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt     = count_r + CNT_W'(1);
          cursor_nxt    = '0;
          mem_cmd.wr_en = 1'b1;
          mem_addr      = slot_back_push;
        end
      end
      REQ_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          front_nxt  = wrap(SUM_W'(front_r) + SUM_W'(1));
          count_nxt  = count_r - CNT_W'(1);
          cursor_nxt = '0;
        end
      end
      REQ_POP_BACK: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt  = count_r - CNT_W'(1);
          cursor_nxt = '0;
        end
      end
      REQ_PEEK_FRONT: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_sel_nxt    = 1'b1;
          mem_cmd.rd_en = 1'b1;
          mem_addr      = front_r;
        end
      end
      REQ_PEEK_BACK: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_sel_nxt    = 1'b1;
          mem_cmd.rd_en = 1'b1;
          mem_addr      = slot_back_peek;
        end
      end
      REQ_CURSOR_RD: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          rd_sel_nxt    = 1'b1;
          mem_cmd.rd_en = 1'b1;
          mem_addr      = slot_cursor;
          cursor_nxt    = (cur_inc >= count_r) ? '0 : cur_inc[IDX_W-1:0];
        end
      end
      default: begin
        // Unused code: no state change, report ok.
      end
    endcase
    if (!accept) begin
      mem_cmd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      cursor_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= accept;
      if (accept) begin
        front_r  <= front_nxt;
        count_r  <= count_nxt;
        cursor_r <= cursor_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status_r <= status_nxt;
      res_rd_sel_r <= rd_sel_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/circular_deque_with_cursor_unit.sv -----
// Top level of the circular deque with cursor.
// Instantiates cdq_ctrl (pointers, cursor, status) and cdq_ring (store);
// depends on cdq_pkg.
//
//   channel  | ports                                         | handshake
//   ---------+-----------------------------------------------+---------------------
//   request  | in_req_type, in_entry_data                    | start high, busy low
//   result   | out_status, out_read_data, out_entry_count    | out_valid, 1 cycle
//
// Cycles: one request per clock once out of reset. A word accepted at a clock edge
// shows its result during the cycle after that edge; the ring read port and the
// status registers hold that result.
// Reset: synchronous, active low; clears front, count, cursor and the strobe.
// busy is high during reset and the first cycle after it. The ring store is
// not cleared: only live entries are ever read.
// Stalls: none. The receiver cannot hold results off, and busy stays low once
// out of reset, so a new word may arrive on every edge.
`default_nettype none

module circular_deque_with_cursor_unit #(
  parameter int DEPTH      = cdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = cdq_pkg::DATA_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [2:0]            in_req_type,
  input  wire logic [DATA_WIDTH-1:0] in_entry_data,
  output logic                       out_valid,
  output logic      [1:0]            out_status,
  output logic      [DATA_WIDTH-1:0] out_read_data,
  output logic      [CNT_W-1:0]      out_entry_count
);
  import cdq_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                  busy_r;
  logic                  accept;
  mem_cmd_t              mem_cmd;
  logic [IDX_W-1:0]      mem_addr;
  logic [DATA_WIDTH-1:0] ring_q_r;
  logic                  res_valid_r;
  status_t               res_status_r;
  logic                  res_rd_sel_r;
  logic [CNT_W-1:0]      count_r;

  // Hold off requests while in reset and for the cycle after it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  // Decode the request, advance pointers and cursor, issue the ring access.
  cdq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .req_type    (in_req_type),
    .mem_cmd     (mem_cmd),
    .mem_addr    (mem_addr),
    .res_valid_r (res_valid_r),
    .res_status_r(res_status_r),
    .res_rd_sel_r(res_rd_sel_r),
    .count_r     (count_r)
  );

  // Store pushed words; return peeked or cursor words in the following cycle.
  cdq_ring #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ring (
    .clk    (clk),
    .cmd    (mem_cmd),
    .addr   (mem_addr),
    .wdata  (in_entry_data),
    .rdata_r(ring_q_r)
  );

  // Drive the result word. Read data is zero unless the request read the ring;
  // the count register already holds the value after the request.
  assign out_valid       = res_valid_r;
  assign out_status      = res_status_r;
  assign out_read_data   = res_rd_sel_r ? ring_q_r : '0;
  assign out_entry_count = count_r;

endmodule

`default_nettype wire
